[design/scsc_pkg.sv]
// Shared types, codes and step tables of the sensorless six-step commutator.
package scsc_pkg;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] NUM_STEPS = 3'd6;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned THRESH_W = 15;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd102;
  localparam logic signed [LIMIT_W-1:0] LIMIT_RESET = 16'sd32767;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_OV   = 2'd1,
    FAULT_OC   = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    DRV_FLOAT = 2'd0,
    DRV_LOW   = 2'd1,
    DRV_HIGH  = 2'd2
  } drive_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA   = 3'd0,
    REG_THRESH  = 3'd1,
    REG_VLIMIT  = 3'd2,
    REG_ILIMIT  = 3'd3,
    REG_FORWARD = 3'd4,
    REG_DUTY    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic ov;
    logic oc;
  } lane_flag_t;

  typedef struct packed {
    drive_e a;
    drive_e b;
    drive_e c;
  } drive_t;

  typedef struct packed {
    fault_e              fault;
    logic                commutated;
    logic [STEP_W-1:0]   step_now;
    drive_t              drive;
    logic [DUTY_W-1:0]   duty;
  } result_t;

  // Drive pattern of phases A, B and C for each commutation step.
  function automatic drive_t drive_of(input logic [STEP_W-1:0] step);
    drive_t d;
    case (step)
      3'd0:    d = '{a: DRV_HIGH,  b: DRV_LOW,   c: DRV_FLOAT};
      3'd1:    d = '{a: DRV_LOW,   b: DRV_HIGH,  c: DRV_FLOAT};
      3'd2:    d = '{a: DRV_LOW,   b: DRV_FLOAT, c: DRV_HIGH};
      3'd3:    d = '{a: DRV_FLOAT, b: DRV_LOW,   c: DRV_HIGH};
      3'd4:    d = '{a: DRV_HIGH,  b: DRV_FLOAT, c: DRV_LOW};
      3'd5:    d = '{a: DRV_FLOAT, b: DRV_HIGH,  c: DRV_LOW};
      default: d = '{a: DRV_HIGH,  b: DRV_LOW,   c: DRV_FLOAT};
    endcase
    return d;
  endfunction

  // Phase left floating in each step: 0 is A, 1 is B, 2 is C.
  function automatic logic [1:0] float_phase(input logic [STEP_W-1:0] step);
    logic [1:0] p;
    case (step)
      3'd0, 3'd1: p = 2'd2;
      3'd2, 3'd4: p = 2'd1;
      3'd3, 3'd5: p = 2'd0;
      default:    p = 2'd2;
    endcase
    return p;
  endfunction

endpackage

[design/scsc_if.sv]
// Handshake interfaces for the sample, result and configuration channels.
interface scsc_sample_if #(
  parameter int unsigned SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] volt_a;
  logic signed [SW-1:0] volt_b;
  logic signed [SW-1:0] volt_c;
  logic signed [SW-1:0] amp_a;
  logic signed [SW-1:0] amp_b;
  logic signed [SW-1:0] amp_c;

  modport source (output valid, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
                  input ready);
  modport sink (input valid, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
                output ready);
endinterface

interface scsc_result_if;
  logic                         valid;
  logic                         ready;
  scsc_pkg::fault_e             fault;
  logic                         commutated;
  logic [scsc_pkg::STEP_W-1:0]  step_now;
  scsc_pkg::drive_e             drive_a;
  scsc_pkg::drive_e             drive_b;
  scsc_pkg::drive_e             drive_c;
  logic [scsc_pkg::DUTY_W-1:0]  duty_out;

  modport source (output valid, fault, commutated, step_now, drive_a, drive_b, drive_c,
                  duty_out, input ready);
  modport sink (input valid, fault, commutated, step_now, drive_a, drive_b, drive_c,
                duty_out, output ready);
endinterface

interface scsc_cfg_if #(
  parameter int unsigned DW = 17
);
  logic                           valid;
  logic                           ready;
  logic [scsc_pkg::CFG_IDX_W-1:0] index;
  logic [DW-1:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/scsc_lane.sv]
// One phase lane: limit check of the sample pair and the back-EMF voltage filter.
module scsc_lane #(
  parameter int unsigned SW  = 16,
  parameter int unsigned AFB = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic signed [SW-1:0]               volt_i,
  input  logic signed [SW-1:0]               amp_i,
  input  logic signed [scsc_pkg::LIMIT_W-1:0] vlimit_i,
  input  logic signed [scsc_pkg::LIMIT_W-1:0] ilimit_i,
  input  logic                               update_i,
  input  logic [AFB:0]                       alpha_i,
  output scsc_pkg::lane_flag_t               flag_o,
  output logic signed [SW-1:0]               filt_o
);
  import scsc_pkg::*;

  localparam int unsigned CW = (SW > LIMIT_W) ? SW : LIMIT_W;
  localparam int unsigned PW = SW + AFB + 3;

  logic signed [SW-1:0] volt_q;
  lane_flag_t           flag_q;
  logic signed [SW-1:0] filt_q, filt_d;
  logic signed [SW:0]   diff;
  logic signed [AFB+1:0] alpha_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic signed [SW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      volt_q    <= volt_i;
      flag_q.ov <= CW'(volt_i) > CW'(vlimit_i);
      flag_q.oc <= CW'(amp_i) > CW'(ilimit_i);
    end
  end

  // f' = f + floor(a * (x - f) / 2^AFB), which equals the weighted mix of x and f.
  always_comb begin
    diff    = (SW + 1)'(volt_q) - (SW + 1)'(filt_q);
    alpha_s = {1'b0, alpha_i};
    prod    = PW'(diff) * PW'(alpha_s);
    prod_sh = prod >>> AFB;
    sum     = (SW + 1)'(filt_q) + prod_sh[SW:0];
    filt_d  = sum[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else if (update_i) begin
      filt_q <= filt_d;
    end
  end

  assign flag_o = flag_q;
  assign filt_o = filt_q;

endmodule

[design/scsc_merge.sv]
// Merge stage: zero-crossing test on the floating phase, step update and result register.
module scsc_merge #(
  parameter int unsigned SW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  scsc_pkg::fault_e                    fault_i,
  input  logic signed [SW-1:0]                filt_i [3],
  input  logic [scsc_pkg::THRESH_W-1:0]       thresh_i,
  input  logic                                forward_i,
  input  logic [scsc_pkg::DUTY_W-1:0]         duty_i,
  output scsc_pkg::result_t                   result_o
);
  import scsc_pkg::*;

  localparam int unsigned CW = ((SW > THRESH_W) ? SW : THRESH_W) + 2;

  logic [STEP_W-1:0]    step_q;
  logic                 edge_falling_q;
  result_t              result_q, result_d;
  logic [STEP_W-1:0]    step_cur, step_next, step_new;
  logic signed [SW-1:0] fv;
  logic signed [CW-1:0] fv_ext, thr_ext;
  logic                 crossed, advance;

  always_comb begin
    step_cur = (step_q < NUM_STEPS) ? step_q : '0;
    fv       = filt_i[float_phase(step_cur)];
    fv_ext   = CW'(fv);
    thr_ext  = CW'(signed'({1'b0, thresh_i}));
    crossed  = edge_falling_q ? (fv_ext < -thr_ext) : (fv_ext > thr_ext);
    advance  = crossed && (fault_i == FAULT_NONE);
    if (forward_i) begin
      step_next = (step_cur == LAST_STEP) ? '0 : step_cur + 3'd1;
    end else begin
      step_next = (step_cur == '0) ? LAST_STEP : step_cur - 3'd1;
    end
    step_new            = advance ? step_next : step_cur;
    result_d.fault      = fault_i;
    result_d.commutated = advance;
    result_d.step_now   = step_new;
    result_d.drive      = drive_of(step_new);
    result_d.duty       = duty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= '0;
      edge_falling_q <= 1'b0;
    end else if (load_i && advance) begin
      step_q         <= step_next;
      edge_falling_q <= ~edge_falling_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

[design/sensorless_six_step_commutator_top.sv]
// A sample beat reaches its result through three register stages
// (lane input, filter and fault, merge result).
// Throughput: one sample beat per cycle unless the result stalls; the filter
// update (one multiply and add) closes each phase lane's loop combinationally.
// A stalled result holds the pipeline; ready is low only while all stages are full.
// Reset clears the filtered voltages, the step and the expected edge, empties the
// pipeline and loads every configuration register with its reset value.
module sensorless_six_step_commutator_top #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scsc_sample_if.sink   sample_i,
  scsc_result_if.source result_o,
  scsc_cfg_if.sink      cfg_i
);
  import scsc_pkg::*;

  localparam int unsigned SW  = SAMPLE_BITS;
  localparam int unsigned AFB = ALPHA_FRAC_BITS;
  localparam logic [AFB:0] ALPHA_RESET = (AFB + 1)'(((2 << AFB) + 10) / 20);

  // Configuration registers.
  logic [AFB:0]                alpha_q;
  logic [THRESH_W-1:0]         thresh_q;
  logic signed [LIMIT_W-1:0]   vlimit_q;
  logic signed [LIMIT_W-1:0]   ilimit_q;
  logic                        forward_q;
  logic [DUTY_W-1:0]           duty_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RESET;
      thresh_q  <= THRESH_RESET;
      vlimit_q  <= LIMIT_RESET;
      ilimit_q  <= LIMIT_RESET;
      forward_q <= 1'b1;
      duty_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_ALPHA:   alpha_q   <= cfg_i.data[AFB:0];
        REG_THRESH:  thresh_q  <= cfg_i.data[THRESH_W-1:0];
        REG_VLIMIT:  vlimit_q  <= cfg_i.data[LIMIT_W-1:0];
        REG_ILIMIT:  ilimit_q  <= cfg_i.data[LIMIT_W-1:0];
        REG_FORWARD: forward_q <= cfg_i.data[0];
        REG_DUTY:    duty_q    <= cfg_i.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // A weight above 1.0 always has the top bit set and saturates to exactly 1.0.
  logic [AFB:0] alpha_sat;
  assign alpha_sat = alpha_q[AFB] ? {1'b1, {AFB{1'b0}}} : alpha_q;

  // Pipeline occupancy and stall chain.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic move12, load3;

  assign en3    = !v3_q || result_o.ready;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign move12 = en2 && v1_q;
  assign load3  = en3 && v2_q;
  assign sample_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= sample_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Phase lanes.
  logic signed [SW-1:0] volt [3];
  logic signed [SW-1:0] amp [3];
  logic signed [SW-1:0] filt [3];
  lane_flag_t           flag [3];
  fault_e               fault_s1;
  fault_e               fault_s2_q;
  logic                 lane_update;

  assign volt[0] = sample_i.volt_a;
  assign volt[1] = sample_i.volt_b;
  assign volt[2] = sample_i.volt_c;
  assign amp[0]  = sample_i.amp_a;
  assign amp[1]  = sample_i.amp_b;
  assign amp[2]  = sample_i.amp_c;

  assign lane_update = move12 && (fault_s1 == FAULT_NONE);

  for (genvar p = 0; p < 3; p++) begin : g_lane
    scsc_lane #(
      .SW  (SW),
      .AFB (AFB)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (en1),
      .volt_i   (volt[p]),
      .amp_i    (amp[p]),
      .vlimit_i (vlimit_q),
      .ilimit_i (ilimit_q),
      .update_i (lane_update),
      .alpha_i  (alpha_sat),
      .flag_o   (flag[p]),
      .filt_o   (filt[p])
    );
  end

  // Phases are checked A, B, C, and voltage before current within a phase.
  always_comb begin
    fault_s1 = FAULT_NONE;
    for (int p = 2; p >= 0; p--) begin
      if (flag[p].ov) begin
        fault_s1 = FAULT_OV;
      end else if (flag[p].oc) begin
        fault_s1 = FAULT_OC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      fault_s2_q <= fault_s1;
    end
  end

  result_t result;

  scsc_merge #(
    .SW (SW)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load3),
    .fault_i   (fault_s2_q),
    .filt_i    (filt),
    .thresh_i  (thresh_q),
    .forward_i (forward_q),
    .duty_i    (duty_q),
    .result_o  (result)
  );

  assign result_o.valid      = v3_q;
  assign result_o.fault      = result.fault;
  assign result_o.commutated = result.commutated;
  assign result_o.step_now   = result.step_now;
  assign result_o.drive_a    = result.drive.a;
  assign result_o.drive_b    = result.drive.b;
  assign result_o.drive_c    = result.drive.c;
  assign result_o.duty_out   = result.duty;

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.step_now < NUM_STEPS))
    else $error("step outside the six-step cycle");

  a_fault_no_commutate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.fault != FAULT_NONE)) |-> !result_o.commutated)
    else $error("commutation reported on a faulted sample");

  a_one_high_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ($countones({result_o.drive_a == DRV_HIGH,
                                    result_o.drive_b == DRV_HIGH,
                                    result_o.drive_c == DRV_HIGH}) == 1))
    else $error("drive pattern does not have exactly one high phase");

  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> sample_i.ready)
    else $error("input stalled while the result stage is empty");

endmodule

[dv/tb_sensorless_six_step_commutator_top.sv]
// Self-checking testbench for the sensorless six-step commutator top level.
`timescale 1ns / 1ps

module tb_sensorless_six_step_commutator_top;
  import scsc_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 128;
  localparam int unsigned CALM_PHASE = 3;
  localparam int unsigned IDLE_PERCENT = 26;
  localparam int unsigned ALPHA_SHIFT = 16;
  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // Phase driven high and phase driven low in each step, step 0 in the low bits.
  localparam logic [11:0] HIGH_PH = {2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0};
  localparam logic [11:0] LOW_PH = {2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1};

  typedef struct packed {
    logic signed [15:0] volt_a;
    logic signed [15:0] volt_b;
    logic signed [15:0] volt_c;
    logic signed [15:0] amp_a;
    logic signed [15:0] amp_b;
    logic signed [15:0] amp_c;
  } sample_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    sample_t              smp;
    logic [CFG_IDX_W-1:0] idx;
    logic [16:0]          val;
    bit                   fixed;
    result_t              want;
  } row_t;

  typedef struct {
    bit      fixed;
    result_t want;
  } pin_t;

  logic clk;
  logic rst_n;
  bit   calm;

  scsc_sample_if #(.SW(16)) sample_ch ();
  scsc_result_if            result_ch ();
  scsc_cfg_if #(.DW(17))    cfg_ch ();

  sensorless_six_step_commutator_top u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // Commutator model: configuration and state after reset.
  logic [16:0]        alpha_q = 17'd6554;
  logic [14:0]        thr_q = THRESH_RESET;
  logic signed [15:0] vlim_q = LIMIT_RESET;
  logic signed [15:0] ilim_q = LIMIT_RESET;
  logic               fwd_q = 1'b1;
  logic [15:0]        duty_q = 16'd0;
  logic signed [15:0] filt_q [3] = '{16'sd0, 16'sd0, 16'sd0};
  logic [2:0]         step_q = 3'd0;
  logic               edge_q = 1'b0;

  result_t expected_results [$];
  pin_t    pins [$];
  row_t    dir_rows [$];

  int errors;
  int n_samples;
  int n_steps;
  int n_faults;
  int n_writes;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t advance_commutator(input sample_t s);
    logic signed [15:0] volts [3];
    logic signed [15:0] amps [3];
    longint wt;
    longint acc;
    int p;
    int fv;
    int hi;
    int lo;
    fault_e flt;
    logic moved;
    logic [2:0] st;
    drive_e drv [3];
    result_t r;
    volts[0] = s.volt_a;
    volts[1] = s.volt_b;
    volts[2] = s.volt_c;
    amps[0] = s.amp_a;
    amps[1] = s.amp_b;
    amps[2] = s.amp_c;
    flt = FAULT_NONE;
    moved = 1'b0;
    // Phases are checked in order, voltage before current within a phase.
    for (p = 0; p < 3; p++) begin
      if (flt == FAULT_NONE) begin
        if (volts[p] > vlim_q) flt = FAULT_OV;
        else if (amps[p] > ilim_q) flt = FAULT_OC;
      end
    end
    st = (step_q <= LAST_STEP) ? step_q : 3'd0;
    if (flt == FAULT_NONE) begin
      wt = (alpha_q > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q);
      for (p = 0; p < 3; p++) begin
        acc = wt * longint'(volts[p]) + (longint'(ALPHA_ONE) - wt) * longint'(filt_q[p]);
        filt_q[p] = 16'(acc >>> ALPHA_SHIFT);
      end
      hi = int'(HIGH_PH[2*st +: 2]);
      lo = int'(LOW_PH[2*st +: 2]);
      fv = int'(filt_q[3 - hi - lo]);
      if (edge_q ? (fv < -int'(thr_q)) : (fv > int'(thr_q))) begin
        if (fwd_q) st = (st == LAST_STEP) ? 3'd0 : st + 3'd1;
        else st = (st == 3'd0) ? LAST_STEP : st - 3'd1;
        step_q = st;
        edge_q = ~edge_q;
        moved = 1'b1;
      end
    end
    hi = int'(HIGH_PH[2*st +: 2]);
    lo = int'(LOW_PH[2*st +: 2]);
    for (p = 0; p < 3; p++)
      drv[p] = (p == hi) ? DRV_HIGH : (p == lo) ? DRV_LOW : DRV_FLOAT;
    r.fault = flt;
    r.commutated = moved;
    r.step_now = st;
    r.drive.a = drv[0];
    r.drive.b = drv[1];
    r.drive.c = drv[2];
    r.duty = duty_q;
    return r;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
    case (idx)
      REG_ALPHA:   alpha_q = val;
      REG_THRESH:  thr_q = val[14:0];
      REG_VLIMIT:  vlim_q = val[15:0];
      REG_ILIMIT:  ilim_q = val[15:0];
      REG_FORWARD: fwd_q = val[0];
      REG_DUTY:    duty_q = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic row_t smp_row(input int va, input int vb, input int vc,
                                   input int ia, input int ib, input int ic);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.smp.volt_a = 16'(va);
    r.smp.volt_b = 16'(vb);
    r.smp.volt_c = 16'(vc);
    r.smp.amp_a = 16'(ia);
    r.smp.amp_b = 16'(ib);
    r.smp.amp_c = 16'(ic);
    r.idx = '0;
    r.val = '0;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
    row_t r;
    r = smp_row(0, 0, 0, 0, 0, 0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Mostly samples within the limits, some over a limit, some anywhere in range.
  function automatic sample_t gen_sample();
    int vals [6];
    int mode;
    int lim;
    int pick;
    int p;
    sample_t s;
    mode = $urandom_range(99, 0);
    for (p = 0; p < 6; p++) begin
      lim = (p < 3) ? int'(vlim_q) : int'(ilim_q);
      if (mode < 12) vals[p] = int'($signed(16'($urandom)));
      else vals[p] = lim - int'($urandom_range(lim + 32768, 0));
    end
    if (mode >= 82) begin
      pick = $urandom_range(5, 0);
      lim = (pick < 3) ? int'(vlim_q) : int'(ilim_q);
      if (lim < 32767) vals[pick] = lim + 1 + int'($urandom_range(32766 - lim, 0));
    end
    s.volt_a = 16'(vals[0]);
    s.volt_b = 16'(vals[1]);
    s.volt_c = 16'(vals[2]);
    s.amp_a = 16'(vals[3]);
    s.amp_b = 16'(vals[4]);
    s.amp_c = 16'(vals[5]);
    return s;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_sample(input sample_t s, input bit fixed, input result_t want);
    pin_t pin;
    while (!calm && $urandom_range(99, 0) < IDLE_PERCENT) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pin.fixed = fixed;
    pin.want = want;
    pins.push_back(pin);
    sample_ch.valid <= 1'b1;
    sample_ch.volt_a <= s.volt_a;
    sample_ch.volt_b <= s.volt_b;
    sample_ch.volt_c <= s.volt_c;
    sample_ch.amp_a <= s.amp_a;
    sample_ch.amp_b <= s.amp_b;
    sample_ch.amp_c <= s.amp_c;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come back and the pipeline is empty.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [16:0] alpha, input logic [14:0] thr,
                           input logic [15:0] vlim, input logic [15:0] ilim,
                           input logic fwd, input logic [15:0] duty);
    drain();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_THRESH, {2'b00, thr});
    write_reg(REG_VLIMIT, {1'b0, vlim});
    write_reg(REG_ILIMIT, {1'b0, ilim});
    write_reg(REG_FORWARD, {16'd0, fwd});
    write_reg(REG_DUTY, {1'b0, duty});
    write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, 17'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      apply_write(cfg_ch.index, cfg_ch.data);
      n_writes++;
    end
  end

  always @(posedge clk) begin
    sample_t got;
    pin_t pin;
    result_t want;
    if (rst_n && sample_ch.valid && sample_ch.ready) begin
      got.volt_a = sample_ch.volt_a;
      got.volt_b = sample_ch.volt_b;
      got.volt_c = sample_ch.volt_c;
      got.amp_a = sample_ch.amp_a;
      got.amp_b = sample_ch.amp_b;
      got.amp_c = sample_ch.amp_c;
      want = advance_commutator(got);
      pin = pins.pop_front();
      if (pin.fixed) want = pin.want;
      expected_results.push_back(want);
      n_samples++;
      if (want.commutated) n_steps++;
      if (want.fault != FAULT_NONE) n_faults++;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result beat with no sample outstanding, expected none, actual step %0d",
                 $time, result_ch.step_now);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("fault", 32'(want.fault), 32'(result_ch.fault));
        compare_field("commutated", 32'(want.commutated), 32'(result_ch.commutated));
        compare_field("step_now", 32'(want.step_now), 32'(result_ch.step_now));
        compare_field("drive_a", 32'(want.drive.a), 32'(result_ch.drive_a));
        compare_field("drive_b", 32'(want.drive.b), 32'(result_ch.drive_b));
        compare_field("drive_c", 32'(want.drive.c), 32'(result_ch.drive_c));
        compare_field("duty_out", 32'(want.duty), 32'(result_ch.duty_out));
      end
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    row_t r;
    int ph;
    int k;
    logic [16:0] alpha;
    logic [14:0] thr;
    logic [15:0] vlim;
    logic [15:0] ilim;
    logic [15:0] duty;
    rst_n = 1'b0;
    calm = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.volt_a = '0;
    sample_ch.volt_b = '0;
    sample_ch.volt_c = '0;
    sample_ch.amp_a = '0;
    sample_ch.amp_b = '0;
    sample_ch.amp_c = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    // After reset the motor sits in step 0 expecting a rising edge on phase C.
    r = smp_row(0, 0, 0, 0, 0, 0);
    r.fixed = 1'b1;
    r.want = '{fault: FAULT_NONE, commutated: 1'b0, step_now: 3'd0,
               drive: '{a: DRV_HIGH, b: DRV_LOW, c: DRV_FLOAT}, duty: 16'd0};
    dir_rows.push_back(r);
    // Full-scale phase C voltage crosses the threshold; currents at the limit pass.
    r = smp_row(0, 0, 32767, 32767, 32767, 32767);
    r.fixed = 1'b1;
    r.want = '{fault: FAULT_NONE, commutated: 1'b1, step_now: 3'd1,
               drive: '{a: DRV_LOW, b: DRV_HIGH, c: DRV_FLOAT}, duty: 16'd0};
    dir_rows.push_back(r);
    dir_rows.push_back(smp_row(-32768, -32768, -32768, -32768, -32768, -32768));
    dir_rows.push_back(reg_row(REG_DUTY, 17'h0FFFF));
    dir_rows.push_back(reg_row(REG_FORWARD, 17'h00000));
    dir_rows.push_back(smp_row(20000, -20000, 30000, 100, -100, 0));
    dir_rows.push_back(smp_row(-30000, 25000, -30000, 0, 0, 0));
    dir_rows.push_back(smp_row(30000, 30000, 30000, 1, 2, 3));
    dir_rows.push_back(reg_row(REG_VLIMIT, 17'h00000));
    dir_rows.push_back(reg_row(REG_ILIMIT, 17'h00000));
    dir_rows.push_back(smp_row(1, 0, 0, 0, 0, 0));
    dir_rows.push_back(smp_row(0, 0, 0, 1, 0, 0));
    dir_rows.push_back(smp_row(0, 1, 0, 1, 0, 0));
    dir_rows.push_back(smp_row(0, 0, 1, 0, 1, 0));
    dir_rows.push_back(smp_row(0, 5, 0, 0, 5, 0));
    dir_rows.push_back(smp_row(0, 0, 0, 0, 0, 0));
    dir_rows.push_back(reg_row(REG_VLIMIT, 17'h08000));
    dir_rows.push_back(reg_row(REG_ILIMIT, 17'h08000));
    dir_rows.push_back(smp_row(-32768, -32768, -32768, -32768, -32768, -32768));
    dir_rows.push_back(smp_row(-32768, -32768, -32767, -32768, -32768, -32768));
    dir_rows.push_back(smp_row(-32768, -32768, -32768, -32767, -32768, -32768));
    dir_rows.push_back(reg_row(REG_VLIMIT, 17'h07FFF));
    dir_rows.push_back(reg_row(REG_ILIMIT, 17'h07FFF));
    dir_rows.push_back(reg_row(REG_ALPHA, 17'h10000));
    dir_rows.push_back(reg_row(REG_THRESH, 17'h00000));
    dir_rows.push_back(smp_row(32767, 32767, 32767, 0, 0, 0));
    dir_rows.push_back(smp_row(-32768, -32768, -32768, 0, 0, 0));
    dir_rows.push_back(smp_row(1, -1, 1, 0, 0, 0));
    dir_rows.push_back(reg_row(REG_ALPHA, 17'h1FFFF));
    dir_rows.push_back(reg_row(REG_THRESH, 17'h07FFF));
    dir_rows.push_back(smp_row(32767, 32767, 32767, 0, 0, 0));
    dir_rows.push_back(smp_row(-32768, -32768, -32768, 0, 0, 0));
    dir_rows.push_back(reg_row(REG_ALPHA, 17'h00000));
    dir_rows.push_back(reg_row(REG_SPARE_LO, 17'h1FFFF));
    dir_rows.push_back(reg_row(REG_SPARE_HI, 17'h00000));
    dir_rows.push_back(smp_row(32767, 32767, 32767, 0, 0, 0));
    dir_rows.push_back(smp_row(-32768, -32768, -32768, 0, 0, 0));
    dir_rows.push_back(reg_row(REG_ALPHA, 17'd6554));
    dir_rows.push_back(reg_row(REG_THRESH, 17'd102));
    dir_rows.push_back(reg_row(REG_FORWARD, 17'h00001));
    dir_rows.push_back(reg_row(REG_DUTY, 17'h01234));
    dir_rows.push_back(smp_row(12000, -12000, 12000, -5, 5, -5));
    dir_rows.push_back(smp_row(-12000, 12000, -12000, 5, -5, 5));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        cfg_ch.valid <= 1'b0;
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      alpha = (ph == 0) ? 17'h10000 : (ph == 1) ? 17'h1FFFF : 17'($urandom_range(65536, 512));
      thr = (ph == 2) ? 15'h7FFF : (ph == 3) ? 15'd0 : 15'($urandom_range(3000, 0));
      vlim = (ph == 4) ? 16'h8000 : (ph % 3 == 1) ? 16'($urandom_range(32767, 8000)) : 16'h7FFF;
      ilim = (ph == 5) ? 16'h8000 : (ph % 3 == 2) ? 16'($urandom_range(32767, 8000)) : 16'h7FFF;
      duty = (ph == 6) ? 16'hFFFF : (ph == 7) ? 16'h0000 : 16'($urandom);
      configure(alpha, thr, vlim, ilim, (ph % 2 == 0), duty);
      calm = (ph == CALM_PHASE);
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        send_sample(gen_sample(), 1'b0, '0);
    end
    calm = 1'b0;
    drain();

    $display("Checked %0d sample beats across %0d register writes: %0d commutations, %0d faults.",
             n_samples, n_writes, n_steps, n_faults);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sensorless_six_step_commutator_top.f]
design/scsc_pkg.sv
design/scsc_if.sv
design/scsc_lane.sv
design/scsc_merge.sv
design/sensorless_six_step_commutator_top.sv
dv/tb_sensorless_six_step_commutator_top.sv
